@@ rtl/enms_pkg.sv @@
package enms_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned SizeW     = 11;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  localparam logic [SizeW-1:0] WidthReset  = SizeW'(640);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(480);
  localparam logic [SizeW-1:0] SizeMin     = SizeW'(3);
  localparam logic [SizeW-1:0] WidthMax    = SizeW'(MaxWidth);
  localparam logic [SizeW-1:0] HeightMax   = SizeW'(MaxHeight);

  // quantized gradient direction codes
  localparam logic [7:0] DirH    = 8'd0;
  localparam logic [7:0] DirD45  = 8'd45;
  localparam logic [7:0] DirV    = 8'd90;
  localparam logic [7:0] DirD135 = 8'd135;

  typedef struct packed {
    logic [7:0] magnitude;
    logic [7:0] direction;
  } in_t;

  typedef struct packed {
    logic [7:0] suppressed_value;
    logic       last;
  } out_t;

  // one column of the line buffers
  typedef struct packed {
    logic [7:0] dir_mid;
    logic [7:0] mag_mid;
    logic [7:0] mag_top;
  } line_t;

  typedef struct packed {
    logic            we;
    logic [ColW-1:0] waddr;
    line_t           wdata;
    logic [ColW-1:0] raddr;
  } lb_req_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v,
                                                  logic [SizeW-1:0] hi);
    logic [SizeW-1:0] r;
    r = v;
    if (v < SizeMin) r = SizeMin;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

@@ rtl/edge_non_max_suppression_unit.sv @@
// Canny non-maximum suppression over a streamed raster.
// Input channel (in_valid_i / in_stall_o / in_data_i): one pixel per
// transfer in raster order, gradient magnitude and direction code.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// interior pixel; border pixels produce none. last marks the final result
// of a frame.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 sets the image
// width, index 1 the height; sizes are clamped to 3..1024. Write only while
// the block is idle. cfg_ready_o is always high.
// The result for the pixel at (r-1, c-1) is registered when the pixel at
// (r, c) is accepted. Throughput: one pixel per clock unless the input
// stalls, set by the line buffer that is written at the current column
// and read one column ahead in the same cycle.
// A stalled result holds in the output register; the input stalls only
// while that register is full and stalled.
// Reset clears the counters, window and output valid; the line buffer is
// not cleared, as every entry is written one line before it is read.
module edge_non_max_suppression_unit import enms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i
);

  logic [SizeW-1:0] width_q, height_q;
  logic [SizeW-1:0] w_eff, h_eff;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [7:0]       wm_q [6];
  logic [7:0]       wd_q [2];
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             accept, col_end, row_end, interior;
  lb_req_t          lb_req;
  line_t            lb_rd;
  logic [7:0]       centre, na, nb;
  logic             dir_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(width_q, WidthMax);
  assign h_eff = clamp_size(height_q, HeightMax);

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_end  = ({1'b0, col_q} + SizeW'(1)) >= w_eff;
  assign row_end  = ({1'b0, row_q} + SizeW'(1)) >= h_eff;
  assign interior = (row_q >= RowW'(2)) && (col_q >= ColW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // read one column ahead so the data waits in the read register
  always_comb begin
    lb_req.we            = accept;
    lb_req.waddr         = col_q;
    lb_req.wdata.mag_top = lb_rd.mag_mid;
    lb_req.wdata.mag_mid = in_data_i.magnitude;
    lb_req.wdata.dir_mid = in_data_i.direction;
    lb_req.raddr         = col_d;
  end

  enms_line_buf u_line_buf (
    .clk_i (clk_i),
    .req_i (lb_req),
    .rd_o  (lb_rd)
  );

  assign centre = wm_q[4];

  always_comb begin
    na     = '0;
    nb     = '0;
    dir_ok = 1'b1;
    case (wd_q[1])
      DirH: begin
        na = wm_q[1];
        nb = lb_rd.mag_mid;
      end
      DirD45: begin
        na = lb_rd.mag_top;
        nb = wm_q[2];
      end
      DirV: begin
        na = wm_q[3];
        nb = wm_q[5];
      end
      DirD135: begin
        na = wm_q[0];
        nb = in_data_i.magnitude;
      end
      default: dir_ok = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (accept) begin
      out_valid_d            = interior;
      out_d.suppressed_value = (!dir_ok || centre < na || centre < nb) ? 8'd0 : centre;
      out_d.last             = row_end && col_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) wm_q[i] <= '0;
      wd_q[0]     <= '0;
      wd_q[1]     <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        wm_q[0] <= wm_q[3];
        wm_q[1] <= wm_q[4];
        wm_q[2] <= wm_q[5];
        wm_q[3] <= lb_rd.mag_top;
        wm_q[4] <= lb_rd.mag_mid;
        wm_q[5] <= in_data_i.magnitude;
        wd_q[0] <= wd_q[1];
        wd_q[1] <= lb_rd.dir_mid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/enms_line_buf.sv @@
module enms_line_buf import enms_pkg::*; (
  input  logic    clk_i,
  input  lb_req_t req_i,
  output line_t   rd_o
);

  line_t mem [MaxWidth];
  line_t rd_q;

  // read and write addresses never coincide in a cycle that writes
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  assign rd_o = rd_q;

endmodule

@@ rtl/enms_checker.sv @@
module enms_props import enms_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_t                in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_t               out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [SizeW-1:0]   cfg_data_i
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // input stalls only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // while the output is not stalled, no result without an input transfer in the cycle before
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) && !out_stall_i |=> !out_valid_o)
    else $error("result appeared without an input transfer");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind edge_non_max_suppression_unit enms_props u_enms_props (.*);
